// ===== hw/rtl/kct_pkg.sv =====
// shared types and constants for the keyed compact table
package kct_pkg;

	localparam int MaxEntries = 16;
	localparam int IdxW = $clog2(MaxEntries);
	localparam int CntW = $clog2(MaxEntries + 1);
	localparam int KeyW = 16;
	localparam int DoseW = 16;

	typedef logic [IdxW-1:0] idx_t;
	typedef logic [CntW-1:0] cnt_t;
	typedef logic [KeyW+DoseW-1:0] entry_t;

	// command codes
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_DEL = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DUP = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

endpackage

// ===== hw/rtl/keyed_compact_table.sv =====
// keyed compact table: list of unique keys with doses in insertion order, one memory walked by a sequencer
// flow: add on a full table or an unused mode goes from accept straight to the response state; add,
//   delete and lookup walk the entries through one registered memory read port, one entry a cycle,
//   until a hit or the last entry, and a delete then shifts every entry above the removed one down
//   one place; one transaction at a time, a new command is accepted only when idle
// reset: arst_n clears the sequencer, the entry count and the output valid; stored entries
//   are not cleared and are only read below the entry count
module keyed_compact_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic [kct_pkg::KeyW-1:0]    key,
	input  logic [kct_pkg::DoseW-1:0]   dose_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [3:0]                  position,
	output logic [kct_pkg::DoseW-1:0]   dose_out,
	output logic [4:0]                  entry_count
);

	// sequencer and command registers
	kct_pkg::state_t state_q, state_d;
	logic [1:0]                mode_q;
	logic [kct_pkg::KeyW-1:0]  key_q;
	logic [kct_pkg::DoseW-1:0] dose_q;
	kct_pkg::cnt_t             count_q;

	// walk pointers: iss_q is the next address to read, cmp_idx_q the address of rd_data_q
	kct_pkg::cnt_t             iss_q;
	logic                      rdv_q;
	kct_pkg::idx_t             cmp_idx_q;

	// pending result, latched when the outcome is known
	logic [1:0]                res_status_q;
	kct_pkg::idx_t             res_pos_q;
	logic [kct_pkg::DoseW-1:0] res_dose_q;

	// output register
	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [3:0]                position_q;
	logic [kct_pkg::DoseW-1:0] dose_out_q;
	logic [4:0]                entry_count_q;

	// entry memory, key in the upper half
	kct_pkg::entry_t mem_q [kct_pkg::MaxEntries];
	kct_pkg::entry_t rd_data_q;

	// datapath controls
	logic            in_fire;
	logic            out_free;
	logic            issue;
	logic            mem_we;
	kct_pkg::idx_t   wr_addr;
	kct_pkg::entry_t wr_data;
	logic            hit;
	logic            exhausted;
	logic            full;
	logic [kct_pkg::KeyW-1:0]  rd_key;
	logic [kct_pkg::DoseW-1:0] rd_dose;

	assign in_ready  = (state_q == kct_pkg::S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign rd_key    = rd_data_q[kct_pkg::KeyW+kct_pkg::DoseW-1:kct_pkg::DoseW];
	assign rd_dose   = rd_data_q[kct_pkg::DoseW-1:0];
	// the shared comparator: key of the entry just read against the command key
	assign hit       = rdv_q && (rd_key == key_q);
	// nothing in flight and every live entry already read
	assign exhausted = !rdv_q && (iss_q == count_q);
	assign full      = (count_q == kct_pkg::cnt_t'(kct_pkg::MaxEntries));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kct_pkg::S_IDLE: begin
				if (in_fire) begin
					if ((mode == kct_pkg::MODE_ADD && !full) || mode == kct_pkg::MODE_DEL
							|| mode == kct_pkg::MODE_LOOKUP) begin
						state_d = kct_pkg::S_SCAN;
					end else begin
						state_d = kct_pkg::S_RESP;
					end
				end
			end
			kct_pkg::S_SCAN: begin
				if (hit) begin
					state_d = (mode_q == kct_pkg::MODE_DEL) ? kct_pkg::S_SHIFT : kct_pkg::S_RESP;
				end else if (exhausted) begin
					state_d = kct_pkg::S_RESP;
				end
			end
			kct_pkg::S_SHIFT: begin
				if (exhausted) begin
					state_d = kct_pkg::S_RESP;
				end
			end
			kct_pkg::S_RESP: begin
				if (out_free) begin
					state_d = kct_pkg::S_IDLE;
				end
			end
			default: state_d = kct_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		issue   = 1'b0;
		mem_we  = 1'b0;
		wr_addr = count_q[kct_pkg::IdxW-1:0];
		wr_data = {key_q, dose_q};
		case (state_q)
			kct_pkg::S_SCAN: begin
				issue = (iss_q != count_q);
				// a miss on add appends at the end
				mem_we = exhausted && (mode_q == kct_pkg::MODE_ADD);
			end
			kct_pkg::S_SHIFT: begin
				// entry read from cmp_idx_q moves down one place
				issue   = (iss_q != count_q);
				mem_we  = rdv_q;
				wr_addr = cmp_idx_q - kct_pkg::idx_t'(1);
				wr_data = rd_data_q;
			end
			default: ;
		endcase
	end

	// entry memory with registered read
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_q <= mem_q[iss_q[kct_pkg::IdxW-1:0]];
		end
		if (mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kct_pkg::S_IDLE;
			count_q     <= '0;
			rdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == kct_pkg::S_SCAN && hit) begin
				rdv_q <= 1'b0;
			end else begin
				rdv_q <= issue;
			end
			if (state_q == kct_pkg::S_SCAN && exhausted && mode_q == kct_pkg::MODE_ADD) begin
				count_q <= count_q + kct_pkg::cnt_t'(1);
			end else if (state_q == kct_pkg::S_SHIFT && exhausted) begin
				count_q <= count_q - kct_pkg::cnt_t'(1);
			end
			if (state_q == kct_pkg::S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command, walk pointers and result payload
	always_ff @(posedge clk) begin
		if (issue) begin
			cmp_idx_q <= iss_q[kct_pkg::IdxW-1:0];
			// a hit ends the scan, so the pointer is not advanced; delete and lookup set it below
			if (!(state_q == kct_pkg::S_SCAN && hit)) begin
				iss_q <= iss_q + kct_pkg::cnt_t'(1);
			end
		end
		case (state_q)
			kct_pkg::S_IDLE: begin
				if (in_fire) begin
					mode_q       <= mode;
					key_q        <= key;
					dose_q       <= dose_in;
					iss_q        <= '0;
					res_status_q <= (mode == kct_pkg::MODE_ADD && full) ? kct_pkg::ST_FULL
						: kct_pkg::ST_OK;
					res_pos_q    <= '0;
					res_dose_q   <= '0;
				end
			end
			kct_pkg::S_SCAN: begin
				if (hit) begin
					if (mode_q == kct_pkg::MODE_ADD) begin
						res_status_q <= kct_pkg::ST_DUP;
					end else begin
						res_pos_q <= cmp_idx_q;
						// shift starts with the entry just above the removed one
						iss_q <= {1'b0, cmp_idx_q} + kct_pkg::cnt_t'(1);
						if (mode_q == kct_pkg::MODE_LOOKUP) begin
							res_dose_q <= rd_dose;
						end
					end
				end else if (exhausted) begin
					if (mode_q == kct_pkg::MODE_ADD) begin
						res_pos_q <= count_q[kct_pkg::IdxW-1:0];
					end else begin
						res_status_q <= kct_pkg::ST_MISSING;
					end
				end
			end
			kct_pkg::S_RESP: begin
				if (out_free) begin
					status_q      <= res_status_q;
					position_q    <= 4'(res_pos_q);
					dose_out_q    <= res_dose_q;
					entry_count_q <= 5'(count_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign dose_out    = dose_out_q;
	assign entry_count = entry_count_q;

endmodule
